### hw/rtl/uart_frame_xor_deframer_macros.svh
// assertion helpers for the frame deframer
`ifndef UART_FRAME_XOR_DEFRAMER_MACROS_SVH
`define UART_FRAME_XOR_DEFRAMER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define UFXD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ufxd assertion failed");
// next-cycle implication
`define UFXD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ufxd assertion failed");
`else
`define UFXD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define UFXD_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

### hw/rtl/ufxd_pkg.sv
`default_nettype none

package ufxd_pkg;

    // frame length must be below this
    localparam logic [7:0] LEN_LIMIT = 8'd100;

    // end marker after reset
    localparam logic [7:0] MARKER_RESET = 8'd10;

    // one result item
    typedef struct packed {
        logic [7:0] data;
        logic       pvalid;
        logic       last;
    } item_t;

endpackage

`default_nettype wire

### hw/rtl/ufxd_ring.sv
`default_nettype none

module ufxd_ring #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          we,
    input  wire logic [AW-1:0] waddr,
    input  wire logic [7:0]    wdata,
    input  wire logic          re,
    input  wire logic [AW-1:0] raddr,
    output logic      [7:0]    rdata
);

    logic [7:0]       mem [DEPTH];
    logic [DEPTH-1:0] vld_reg;
    logic [7:0]       rraw_reg;
    logic             rvld_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rraw_reg <= mem[raddr];
        end
    end

    // entries never written read as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            rvld_reg <= 1'b0;
        end
        else
        begin
            if (we)
            begin
                vld_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rvld_reg <= vld_reg[raddr];
            end
        end
    end

    assign rdata = rvld_reg ? rraw_reg : 8'd0;

endmodule

`default_nettype wire

### hw/rtl/ufxd_ctrl.sv
`default_nettype none

module ufxd_ctrl
    import ufxd_pkg::*;
#(
    parameter int RING_DEPTH = 64
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    rx_byte,
    input  wire logic [7:0]                    end_marker,
    output logic                               we,
    output logic [$clog2(RING_DEPTH)-1:0]      waddr,
    output logic [7:0]                         wdata,
    output logic                               re,
    output logic [$clog2(RING_DEPTH)-1:0]      raddr,
    input  wire logic [7:0]                    rdata,
    input  wire logic                          out_free,
    output logic                               emit_valid,
    output item_t                              emit_item
);

    localparam int AW = $clog2(RING_DEPTH);
    localparam logic [AW:0] DEPTH_W = (AW+1)'(RING_DEPTH);
    localparam logic [AW-1:0] LAST_IDX = AW'(RING_DEPTH - 1);
    localparam logic [8:0] LEN_FIT = 9'(RING_DEPTH);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_LEN   = 3'd1;
    localparam logic [2:0] S_CHK   = 3'd2;
    localparam logic [2:0] S_SUM   = 3'd3;
    localparam logic [2:0] S_EREAD = 3'd4;
    localparam logic [2:0] S_EPUT  = 3'd5;

    // base minus back, modulo the ring depth
    function automatic logic [AW-1:0] back_idx(input logic [AW-1:0] base,
                                                input logic [AW-1:0] back);
        logic [AW:0] s;
        s = {1'b0, base} + (DEPTH_W - {1'b0, back});
        if (s >= DEPTH_W)
        begin
            s = s - DEPTH_W;
        end
        return s[AW-1:0];
    endfunction

    function automatic logic [AW-1:0] inc_idx(input logic [AW-1:0] v);
        return (v == LAST_IDX) ? '0 : v + 1'b1;
    endfunction

    logic [2:0]    state_reg, state_next;
    logic [AW-1:0] wp_reg, wp_next;
    logic [AW-1:0] cnt_reg, cnt_next;
    logic [AW-1:0] endp_reg, endp_next;
    logic [AW-1:0] lenpos_reg, lenpos_next;
    logic [AW-1:0] len_reg, len_next;
    logic [AW-1:0] start_reg, start_next;
    logic [AW-1:0] ptr_reg, ptr_next;
    logic [AW-1:0] idx_reg, idx_next;
    logic [7:0]    chk_reg, chk_next;
    logic [7:0]    sum_reg, sum_next;

    logic          accept;
    logic [AW:0]   cnt_inc;
    logic [7:0]    sum_new;
    logic          is_last;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign we       = accept;
    assign waddr    = wp_reg;
    assign wdata    = rx_byte;
    assign cnt_inc  = {1'b0, cnt_reg} + 1'b1;
    assign sum_new  = sum_reg ^ rdata;
    assign is_last  = (len_reg == '0) || ((idx_reg + 1'b1) == len_reg);

    assign emit_valid       = (state_reg == S_EPUT);
    assign emit_item.data   = (len_reg == '0) ? 8'd0 : rdata;
    assign emit_item.pvalid = (len_reg != '0);
    assign emit_item.last   = is_last;

    always_comb
    begin
        state_next  = state_reg;
        wp_next     = wp_reg;
        cnt_next    = cnt_reg;
        endp_next   = endp_reg;
        lenpos_next = lenpos_reg;
        len_next    = len_reg;
        start_next  = start_reg;
        ptr_next    = ptr_reg;
        idx_next    = idx_reg;
        chk_next    = chk_reg;
        sum_next    = sum_reg;
        re          = 1'b0;
        raddr       = ptr_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (cnt_inc >= DEPTH_W)
                    begin
                        // store full: start over at position zero
                        cnt_next = '0;
                        wp_next  = '0;
                    end
                    else
                    begin
                        cnt_next = cnt_inc[AW-1:0];
                        wp_next  = inc_idx(wp_reg);
                        if (rx_byte == end_marker)
                        begin
                            endp_next   = wp_reg;
                            lenpos_next = back_idx(wp_reg, AW'(2));
                            re          = 1'b1;
                            raddr       = back_idx(wp_reg, AW'(2));
                            state_next  = S_LEN;
                        end
                    end
                end
            end
            S_LEN:
            begin
                if ((rdata < LEN_LIMIT) && (({1'b0, rdata} + 9'd3) <= LEN_FIT))
                begin
                    len_next   = rdata[AW-1:0];
                    start_next = back_idx(lenpos_reg, rdata[AW-1:0]);
                    ptr_next   = back_idx(lenpos_reg, rdata[AW-1:0]);
                    re         = 1'b1;
                    raddr      = back_idx(endp_reg, AW'(1));
                    state_next = S_CHK;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_CHK:
            begin
                chk_next   = rdata;
                re         = 1'b1;
                raddr      = ptr_reg;
                ptr_next   = inc_idx(ptr_reg);
                idx_next   = '0;
                sum_next   = 8'd0;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                sum_next = sum_new;
                if (idx_reg == len_reg)
                begin
                    if (sum_new == chk_reg)
                    begin
                        cnt_next   = '0;
                        idx_next   = '0;
                        ptr_next   = start_reg;
                        state_next = (len_reg == '0) ? S_EPUT : S_EREAD;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
                else
                begin
                    idx_next = idx_reg + 1'b1;
                    re       = 1'b1;
                    raddr    = ptr_reg;
                    ptr_next = inc_idx(ptr_reg);
                end
            end
            S_EREAD:
            begin
                re         = 1'b1;
                raddr      = ptr_reg;
                ptr_next   = inc_idx(ptr_reg);
                state_next = S_EPUT;
            end
            S_EPUT:
            begin
                if (out_free)
                begin
                    if (is_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + 1'b1;
                        state_next = S_EREAD;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            wp_reg    <= '0;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            wp_reg    <= wp_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        endp_reg   <= endp_next;
        lenpos_reg <= lenpos_next;
        len_reg    <= len_next;
        start_reg  <= start_next;
        ptr_reg    <= ptr_next;
        idx_reg    <= idx_next;
        chk_reg    <= chk_next;
        sum_reg    <= sum_next;
    end

endmodule

`default_nettype wire

### hw/rtl/uart_frame_xor_deframer.sv
// uart_frame_xor_deframer: checks length/xor framed byte streams and emits the payload
// input channel: rx_byte with in_valid/in_stall, one received byte per transaction
// output channel: payload_byte, payload_valid, last with out_valid/out_stall
// config channel: cfg_data with cfg_valid/cfg_ready sets the end marker (reset 10);
//   cfg_ready is always high, write only while the block is idle
// frame: payload bytes, length L, xor of payload and L, end marker
// every byte is written into a RING_DEPTH entry ring memory;
//   a byte that is not an end marker leaves the block ready the next cycle
// an end marker starts a walk over the ring through its single read port:
//   length read, checksum read, then L+1 reads for the xor, one per cycle
// a good frame is then read out again byte by byte
//   (read, then hand to the output register); an empty frame gives one item
//   with payload_valid low and last high
// busy after an end marker: the walk and, for a good frame, the readout, which
//   waits while out_stall holds it; a checksum mismatch ends after the xor reads,
//   an out-of-range length after the length read; in_stall is high meanwhile
// the output register holds a transaction while out_stall is high and the
//   readout waits; a new byte is taken while the last item still sits there
// reset clears the write pointer, the byte count and the per-entry valid bits of
//   the ring (unwritten entries read as zero); no clearing pass is needed
`default_nettype none

`include "uart_frame_xor_deframer_macros.svh"

module uart_frame_xor_deframer
    import ufxd_pkg::*;
#(
    parameter int RING_DEPTH = 64
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [7:0] rx_byte,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      payload_byte,
    output logic            payload_valid,
    output logic            last,
    input  wire logic       cfg_valid,
    output logic            cfg_ready,
    input  wire logic [7:0] cfg_data
);

    localparam int AW = $clog2(RING_DEPTH);

    // ring memory port
    logic          we;
    logic [AW-1:0] waddr;
    logic [7:0]    wdata;
    logic          re;
    logic [AW-1:0] raddr;
    logic [7:0]    rdata;

    // end marker register
    logic [7:0]    marker_reg;

    // output register
    logic          ovalid_reg;
    item_t         oitem_reg;

    logic          out_free;
    logic          emit_valid;
    item_t         emit_item;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            marker_reg <= MARKER_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            marker_reg <= cfg_data;
        end
    end

    ufxd_ring #(
        .DEPTH (RING_DEPTH),
        .AW    (AW)
    ) u_ring (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .re    (re),
        .raddr (raddr),
        .rdata (rdata)
    );

    ufxd_ctrl #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .end_marker (marker_reg),
        .we         (we),
        .waddr      (waddr),
        .wdata      (wdata),
        .re         (re),
        .raddr      (raddr),
        .rdata      (rdata),
        .out_free   (out_free),
        .emit_valid (emit_valid),
        .emit_item  (emit_item)
    );

    // free when empty or being taken this cycle
    assign out_free = !ovalid_reg || !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ovalid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            ovalid_reg <= emit_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && emit_valid)
        begin
            oitem_reg <= emit_item;
        end
    end

    assign out_valid     = ovalid_reg;
    assign payload_byte  = oitem_reg.data;
    assign payload_valid = oitem_reg.pvalid;
    assign last          = oitem_reg.last;

    // an empty-frame item always closes its frame
    `UFXD_ASSERT_IMP(a_empty_is_last, clk, rst_n, out_valid && !payload_valid, last)
    // readout never overlaps byte intake
    `UFXD_ASSERT_IMP(a_emit_blocks_in, clk, rst_n, emit_valid, in_stall)
    // a byte just taken cannot produce an item in the next cycle
    `UFXD_ASSERT_NEXT(a_no_early_emit, clk, rst_n, in_valid && !in_stall, !emit_valid)

endmodule

`default_nettype wire

### bench/uart_frame_xor_deframer_tb.sv
`default_nettype none

module uart_frame_xor_deframer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import ufxd_pkg::*;

    localparam int DEPTH = 64;
    localparam int MAX_GAP = 9;
    // longest walk after an end marker is for a 61-byte frame, keep some margin
    localparam int WALK_CYCLES = 200;
    // cycles with no transaction on any channel before the run is given up
    localparam int QUIET_LIMIT = 4000;
    localparam int REPORT_LIMIT = 10;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] rx_byte = 8'h00;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] payload_byte;
    logic       payload_valid;
    logic       last;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [7:0] cfg_data = 8'h00;

    uart_frame_xor_deframer #(
        .RING_DEPTH(DEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .rx_byte      (rx_byte),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .payload_byte (payload_byte),
        .payload_valid(payload_valid),
        .last         (last),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    initial
    begin
        forever #2 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // deframer copy: ring of recent bytes, write pointer, byte count since
    // the last good frame and the current end marker
    // ------------------------------------------------------------------
    logic [7:0] ring_copy [DEPTH];
    int         wr_pos = 0;
    int         since_frame = 0;
    logic [7:0] marker_copy = MARKER_RESET;

    // payload items still owed by the block, oldest first
    item_t      expected_payload [$];

    int         mismatches = 0;
    int         bytes_sent = 0;
    int         stall_left = 0;
    int         quiet_cycles = 0;
    bit         in_hold = 1'b0;    // in_valid is being driven high
    bit         steady = 1'b0;     // no idling on either side

    initial
    begin
        foreach (ring_copy[i])
            ring_copy[i] = 8'h00;
    end

    // store one byte and queue the payload items it releases, if any
    function automatic void deframe_byte(input logic [7:0] b);
        int         endp;
        int         len;
        int         start;
        logic [7:0] sum;
        item_t      it;
        ring_copy[wr_pos] = b;
        wr_pos = (wr_pos + 1) % DEPTH;
        since_frame++;
        // ring full: start over from entry 0, no frame check on this byte
        if (since_frame >= DEPTH)
        begin
            since_frame = 0;
            wr_pos = 0;
            return;
        end
        endp = (wr_pos + DEPTH - 1) % DEPTH;
        if (ring_copy[endp] != marker_copy)
            return;
        len = int'(ring_copy[(endp + DEPTH - 2) % DEPTH]);
        // oversized length: marker ignored
        if (len >= int'(LEN_LIMIT) || len + 3 > DEPTH)
            return;
        // the walk may reach bytes older than the current frame
        start = (endp + 2 * DEPTH - 2 - len) % DEPTH;
        sum = 8'h00;
        for (int i = 0; i <= len; i++)
            sum ^= ring_copy[(start + i) % DEPTH];
        // bad checksum keeps the byte count
        if (sum != ring_copy[(endp + DEPTH - 1) % DEPTH])
            return;
        since_frame = 0;
        if (len == 0)
        begin
            // empty frame: one item with no data
            it.data = 8'h00;
            it.pvalid = 1'b0;
            it.last = 1'b1;
            expected_payload.push_back(it);
            return;
        end
        for (int i = 0; i < len; i++)
        begin
            it.data = ring_copy[(start + i) % DEPTH];
            it.pvalid = 1'b1;
            it.last = (i == len - 1);
            expected_payload.push_back(it);
        end
    endfunction

    // ------------------------------------------------------------------
    // input side
    // ------------------------------------------------------------------

    // drop in_valid unless it is already low
    task automatic release_input();
        if (in_hold)
        begin
            in_valid <= 1'b0;
            in_hold = 1'b0;
        end
    endtask

    // one byte transaction; valid stays high afterward so that a byte sent
    // in the same step follows back to back, every other path releases it
    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap > 0)
        begin
            release_input();
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        in_hold = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
        bytes_sent++;
        deframe_byte(b);
    endtask

    // payload, length, checksum, end marker; a bad frame gets a wrong checksum
    task automatic send_frame(input int len, input bit good);
        logic [7:0] chk;
        logic [7:0] pay;
        chk = len[7:0];
        for (int i = 0; i < len; i++)
        begin
            pay = 8'($urandom_range(0, 255));
            chk ^= pay;
            send_byte(pay);
        end
        send_byte(len[7:0]);
        send_byte(good ? chk : chk ^ 8'($urandom_range(1, 255)));
        send_byte(marker_copy);
    endtask

    // mostly short frames, now and then a long one
    function automatic int pick_length();
        int r;
        r = $urandom_range(0, 19);
        if (r < 14)
            return $urandom_range(0, 4);
        else if (r < 19)
            return $urandom_range(5, 12);
        return $urandom_range(13, 40);
    endfunction

    // sender holds off until every owed payload item has come out
    task automatic wait_drained();
        release_input();
        do
            @(posedge clk);
        while (expected_payload.size() != 0);
    endtask

    // a marker whose check fails leaves no result behind, so give the walk
    // time to end before touching the register
    task automatic idle_for_config();
        wait_drained();
        repeat (WALK_CYCLES) @(posedge clk);
    endtask

    task automatic set_end_marker(input logic [7:0] value);
        cfg_valid <= 1'b1;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        marker_copy = value;
    endtask

    // ------------------------------------------------------------------
    // result side: random stall, compare each transaction with the oldest
    // expectation
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : result_check
        item_t got;
        item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            got.data = payload_byte;
            got.pvalid = payload_valid;
            got.last = last;
            if (expected_payload.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected payload item: data %h valid %b last %b",
                             got.data, got.pvalid, got.last);
            end
            else
            begin
                want = expected_payload.pop_front();
                if (got.data !== want.data || got.pvalid !== want.pvalid
                    || got.last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("mismatch: expected %h/%b/%b got %h/%b/%b (data/valid/last)",
                                 want.data, want.pvalid, want.last,
                                 got.data, got.pvalid, got.last);
                end
            end
            // stall after this transaction for a random number of cycles
            stall_left = steady ? 0 : $urandom_range(0, MAX_GAP);
            if (stall_left > 0)
                out_stall <= 1'b1;
        end
        else if (out_stall)
        begin
            stall_left--;
            if (stall_left <= 0)
                out_stall <= 1'b0;
        end
        else if (!steady && $urandom_range(0, 7) == 0)
        begin
            // stall now and then while nothing is offered, so it lands mid-walk
            stall_left = $urandom_range(1, MAX_GAP);
            out_stall <= 1'b1;
        end
    end

    // watchdog: counts cycles without a transaction on any channel
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles++;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles, %0d items owed",
                         quiet_cycles, expected_payload.size());
                $display("FAIL uart_frame_xor_deframer");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // tests
    // ------------------------------------------------------------------

    // right after reset: length 5 with nothing before it reads the zero ring
    task automatic test_short_frame();
        send_byte(8'd5);
        send_byte(8'd5);
        send_byte(MARKER_RESET);
    endtask

    // length 0 and checksum 0: one item with no data, last high
    task automatic test_empty_frame();
        send_byte(8'd0);
        send_byte(8'd0);
        send_byte(marker_copy);
    endtask

    // all-ones and all-zero payload bytes
    task automatic test_extreme_payload();
        send_byte(8'hFF);
        send_byte(8'h00);
        send_byte(8'd2);
        send_byte(8'hFF ^ 8'h00 ^ 8'd2);
        send_byte(marker_copy);
    endtask

    // wrong checksum: nothing comes out and the count keeps running
    task automatic test_bad_checksum();
        send_byte(8'h33);
        send_byte(8'd1);
        send_byte(8'h00);
        send_byte(marker_copy);
    endtask

    // length at the limit, just below it, and too large for the ring
    task automatic test_oversize_length();
        logic [7:0] lens [3];
        lens = '{LEN_LIMIT, LEN_LIMIT - 8'd1, 8'(DEPTH - 2)};
        foreach (lens[i])
        begin
            send_byte(lens[i]);
            send_byte(lens[i]);
            send_byte(marker_copy);
        end
    endtask

    // run the count up to the ring depth with no marker, then a good frame
    task automatic test_ring_wrap();
        logic [7:0] b;
        for (int i = 0; i < DEPTH + 2; i++)
        begin
            do
                b = 8'($urandom_range(0, 255));
            while (b == marker_copy);
            send_byte(b);
        end
        send_frame(3, 1'b1);
    endtask

    // clear the count with an empty frame, then the longest frame that fits
    task automatic test_longest_frame();
        send_frame(0, 1'b1);
        send_frame(DEPTH - 4, 1'b1);
    endtask

    // mix of good frames, bad checksums, noise and oversized lengths
    task automatic run_random_traffic(input int quota);
        int stop_at;
        int kind;
        int n;
        stop_at = bytes_sent + quota;
        while (bytes_sent < stop_at)
        begin
            steady = ($urandom_range(0, 4) == 0);
            kind = $urandom_range(0, 9);
            if (kind <= 5)
                send_frame(pick_length(), 1'b1);
            else if (kind == 6)
                send_frame(pick_length(), 1'b0);
            else if (kind == 7)
            begin
                n = $urandom_range(1, 5);
                repeat (n) send_byte(8'($urandom_range(0, 255)));
            end
            else if (kind == 8)
            begin
                send_byte(8'($urandom_range(DEPTH - 2, 255)));
                send_byte(8'($urandom_range(0, 255)));
                send_byte(marker_copy);
            end
            else
            begin
                // sender waits for the block to catch up before the next frame
                wait_drained();
                send_frame(pick_length(), 1'b1);
            end
        end
        steady = 1'b0;
    endtask

    // four marker settings, extremes included, ending with the reset value
    task automatic test_marker_settings();
        logic [7:0] markers [4];
        markers = '{8'h00, 8'hFF, 8'($urandom_range(0, 255)), MARKER_RESET};
        foreach (markers[i])
        begin
            idle_for_config();
            set_end_marker(markers[i]);
            run_random_traffic(22);
        end
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_short_frame();
        test_empty_frame();
        test_extreme_payload();
        test_bad_checksum();
        test_oversize_length();
        test_ring_wrap();
        test_longest_frame();
        test_marker_settings();

        // let the last walk finish and catch any stray item
        wait_drained();
        repeat (WALK_CYCLES) @(posedge clk);
        if (mismatches == 0 && expected_payload.size() == 0)
            $display("PASS uart_frame_xor_deframer");
        else
            $display("FAIL uart_frame_xor_deframer");
        $finish;
    end

endmodule

`default_nettype wire
